@@ sv/gdd_pkg.sv @@
`timescale 1ns / 1ps

package gdd_pkg;

  // Field widths of the date and result items.
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned DAYS_W  = 22;
  // Day-of-year values fit in 9 bits; the sum of year lengths fits in 23.
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned ACC_W   = 23;
  // Position within the 400-year Gregorian cycle.
  localparam int unsigned CYC_W   = 9;

  localparam logic [CYC_W-1:0]  CYCLE_YEARS = CYC_W'(400);
  localparam logic [CYC_W-1:0]  CYCLE_LAST  = CYC_W'(399);
  localparam logic [CYC_W-1:0]  CENT_1      = CYC_W'(100);
  localparam logic [CYC_W-1:0]  CENT_2      = CYC_W'(200);
  localparam logic [CYC_W-1:0]  CENT_3      = CYC_W'(300);
  localparam logic [ACC_W-1:0]  DAYS_LEAP   = ACC_W'(366);
  localparam logic [ACC_W-1:0]  DAYS_COMMON = ACC_W'(365);
  localparam logic [ACC_W-1:0]  DAYS_MAX    = ACC_W'(4194303);
  localparam logic [MON_W-1:0]  MON_FEB     = MON_W'(2);
  localparam logic [MON_W-1:0]  MON_DEC     = MON_W'(12);

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_YEAR      = 3'd1,
    ST_MONTH     = 3'd2,
    ST_START_DAY = 3'd3,
    ST_END_DAY   = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_LOOP,
    S_ADD_END,
    S_SUB_START,
    S_EMIT
  } state_t;

  // Leap test on a year already reduced into the 400-year cycle.
  function automatic logic is_leap(input logic [CYC_W-1:0] pos);
    logic century;
    century = (pos == CENT_1) || (pos == CENT_2) || (pos == CENT_3);
    return (pos[1:0] == 2'b00) && !century;
  endfunction

  // Length of a month (1 to 12) in a common or leap year.
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the given month.
  function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] mon);
    logic [DOY_W-1:0] cum;
    case (mon)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

  // Day of the year for a checked date.
  function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] day,
                                                   input logic [MON_W-1:0] mon,
                                                   input logic leap);
    logic extra;
    extra = leap && (mon > MON_FEB);
    return days_before(mon) + DOY_W'(day) + DOY_W'(extra);
  endfunction

  // A day is valid when it lies between one and the month's length.
  function automatic logic day_valid(input logic [DAY_W-1:0] day,
                                     input logic [MON_W-1:0] mon,
                                     input logic leap);
    return (day != '0) && (day <= month_days(mon, leap));
  endfunction

endpackage

@@ sv/gdd_if.sv @@
`timescale 1ns / 1ps

// Channel carrying a pair of dates.
interface gdd_in_if;
  import gdd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  start_day;
  logic [MON_W-1:0]  start_month;
  logic [YEAR_W-1:0] start_year;
  logic [DAY_W-1:0]  end_day;
  logic [MON_W-1:0]  end_month;
  logic [YEAR_W-1:0] end_year;

  modport source (output valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, output ready);
endinterface

// Channel carrying the status and day count.
interface gdd_out_if;
  import gdd_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DAYS_W-1:0] total_days;

  modport source (output valid, status, total_days, input ready);
  modport sink   (input valid, status, total_days, output ready);
endinterface

@@ sv/gregorian_date_difference_core.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_ch    sink       start_day, start_month, start_year, end_day, end_month, end_year
// out_ch   source     status, total_days
//
// An item with a bad year order or a bad month goes from idle straight to the emit state.
// Otherwise one shared adder first reduces the start year into the 400-year cycle, then adds
// one year length per cycle, then adds the end day-of-year offset and subtracts the start one.
// Reset (rst_n, synchronous, active low) empties the sequencer and the result register.
// A result waits in the output register; the next item is taken while it waits.

module gregorian_date_difference_core #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic       clk,
  input  logic       rst_n,
  gdd_in_if.sink     in_ch,
  gdd_out_if.source  out_ch
);
  import gdd_pkg::*;

  state_t            state_r, state_nxt;

  logic [DAY_W-1:0]  sd_r, ed_r;
  logic [MON_W-1:0]  sm_r, em_r;
  logic [YEAR_W-1:0] yr_r, ey_r;
  logic [YEAR_W-1:0] pos_r;
  logic              leap_s_r;
  logic [ACC_W-1:0]  acc_r;
  status_t           status_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [DAYS_W-1:0] out_days_r;

  logic              in_fire;
  logic              out_free;
  logic              year_bad;
  logic              month_bad;
  logic              pos_done;
  logic              leap_cur;
  logic              start_ok;
  logic              end_ok;
  logic              years_done;

  logic [ACC_W-1:0]  add_a, add_b, add_sum;
  logic              add_cin;

  logic [DAY_W-1:0]  sd_nxt, ed_nxt;
  logic [MON_W-1:0]  sm_nxt, em_nxt;
  logic [YEAR_W-1:0] yr_nxt, ey_nxt, pos_nxt;
  logic              leap_s_nxt;
  logic [ACC_W-1:0]  acc_nxt;
  status_t           status_nxt;
  logic              out_valid_nxt;
  status_t           out_status_nxt;
  logic [DAYS_W-1:0] out_days_nxt;

  // Handshake and item checks.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign year_bad  = !(in_ch.start_year < in_ch.end_year) ||
                     (32'(in_ch.end_year) > MAX_YEAR);
  assign month_bad = (in_ch.start_month == '0) || (in_ch.start_month > MON_DEC) ||
                     (in_ch.end_month == '0) || (in_ch.end_month > MON_DEC);

  // The cycle position is valid once it drops below 400.
  assign pos_done   = (pos_r < YEAR_W'(CYCLE_YEARS));
  assign leap_cur   = is_leap(pos_r[CYC_W-1:0]);
  assign start_ok   = day_valid(sd_r, sm_r, leap_cur);
  assign end_ok     = day_valid(ed_r, em_r, leap_cur);
  assign years_done = (yr_r == ey_r);

  // Shared adder: cycle reduction, year lengths and day-of-year offsets.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_r)
      S_REDUCE: begin
        add_a   = ACC_W'(pos_r);
        add_b   = ~ACC_W'(CYCLE_YEARS);
        add_cin = 1'b1;
      end
      S_LOOP: begin
        add_a = acc_r;
        add_b = leap_cur ? DAYS_LEAP : DAYS_COMMON;
      end
      S_ADD_END: begin
        add_a = acc_r;
        add_b = ACC_W'(day_of_year(ed_r, em_r, leap_cur));
      end
      S_SUB_START: begin
        add_a   = acc_r;
        add_b   = ~ACC_W'(day_of_year(sd_r, sm_r, leap_s_r));
        add_cin = 1'b1;
      end
      default: begin
        add_a   = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b + ACC_W'(add_cin);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (year_bad || month_bad) ? S_EMIT : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (pos_done) begin
          state_nxt = start_ok ? S_LOOP : S_EMIT;
        end
      end
      S_LOOP: begin
        if (years_done) begin
          state_nxt = end_ok ? S_ADD_END : S_EMIT;
        end
      end
      S_ADD_END:   state_nxt = S_SUB_START;
      S_SUB_START: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result register updates.
  always_comb begin
    sd_nxt         = sd_r;
    sm_nxt         = sm_r;
    ed_nxt         = ed_r;
    em_nxt         = em_r;
    yr_nxt         = yr_r;
    ey_nxt         = ey_r;
    pos_nxt        = pos_r;
    leap_s_nxt     = leap_s_r;
    acc_nxt        = acc_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_days_nxt   = out_days_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sd_nxt  = in_ch.start_day;
          sm_nxt  = in_ch.start_month;
          ed_nxt  = in_ch.end_day;
          em_nxt  = in_ch.end_month;
          yr_nxt  = in_ch.start_year;
          ey_nxt  = in_ch.end_year;
          pos_nxt = in_ch.start_year;
          acc_nxt = '0;
          if (year_bad) begin
            status_nxt = ST_YEAR;
          end else if (month_bad) begin
            status_nxt = ST_MONTH;
          end else begin
            status_nxt = ST_OK;
          end
        end
      end
      S_REDUCE: begin
        if (pos_done) begin
          leap_s_nxt = leap_cur;
          if (!start_ok) begin
            status_nxt = ST_START_DAY;
          end
        end else begin
          pos_nxt = add_sum[YEAR_W-1:0];
        end
      end
      S_LOOP: begin
        if (years_done) begin
          if (!end_ok) begin
            status_nxt = ST_END_DAY;
            acc_nxt    = '0;
          end
        end else begin
          acc_nxt = add_sum;
          yr_nxt  = yr_r + YEAR_W'(1);
          pos_nxt = (pos_r[CYC_W-1:0] == CYCLE_LAST) ? '0 : pos_r + YEAR_W'(1);
        end
      end
      S_ADD_END,
      S_SUB_START: begin
        acc_nxt = add_sum;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_days_nxt   = (acc_r > DAYS_MAX) ? DAYS_MAX[DAYS_W-1:0] : acc_r[DAYS_W-1:0];
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sd_r         <= sd_nxt;
    sm_r         <= sm_nxt;
    ed_r         <= ed_nxt;
    em_r         <= em_nxt;
    yr_r         <= yr_nxt;
    ey_r         <= ey_nxt;
    pos_r        <= pos_nxt;
    leap_s_r     <= leap_s_nxt;
    acc_r        <= acc_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_days_r   <= out_days_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.total_days = out_days_r;

endmodule
